[rtl/plsu_pkg.sv]
// ----------------------------------------------------------------------------
// plsu_pkg - shared types and constants for the positional list store
// Sizes, operation and status codes, and the control bundle that the
// sequencer broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package plsu_pkg;

	localparam int ENTRIES = 256;
	localparam int DATA_W  = 32;

	// fixed field widths
	localparam int KIND_W   = 2;
	localparam int POS_W    = 8;
	localparam int VALUE_W  = 32;
	localparam int RESULT_W = 32;
	localparam int STATUS_W = 2;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

	// read-out tree: first level ORs groups of GRP cells
	localparam int GRP  = 16;
	localparam int NGRP = (ENTRIES + GRP - 1) / GRP;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_GET    = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_SWAP   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_SWAP
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD1,
		S_RD2,
		S_WB
	} state_t;

	typedef struct packed {
		cell_op_t            op;
		logic [IDX_W-1:0]    pos_a;
		logic [IDX_W-1:0]    pos_b;
		logic [DATA_W-1:0]   word_new;
		logic [DATA_W-1:0]   word_a;
		logic [DATA_W-1:0]   word_b;
	} cell_ctl_t;

endpackage

[rtl/plsu_cell.sv]
// ----------------------------------------------------------------------------
// plsu_cell - one list slot
// Holds one word, takes its neighbor's word on insert or remove shifts,
// and offers its word on the two read-out lines when its index is selected.
// ----------------------------------------------------------------------------
module plsu_cell (
	input  logic                          clk,
	input  plsu_pkg::cell_ctl_t           ctl,
	input  logic [plsu_pkg::IDX_W-1:0]    idx,
	input  logic [plsu_pkg::DATA_W-1:0]   left,
	input  logic [plsu_pkg::DATA_W-1:0]   right,
	output logic [plsu_pkg::DATA_W-1:0]   data,
	output logic [plsu_pkg::DATA_W-1:0]   sel_a,
	output logic [plsu_pkg::DATA_W-1:0]   sel_b
);
	import plsu_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;
	logic              hit_a;
	logic              hit_b;

	assign hit_a = (idx == ctl.pos_a);
	assign hit_b = (idx == ctl.pos_b);

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			CELL_INSERT: begin
				if (idx > ctl.pos_a)
					data_d = left;
				else if (hit_a)
					data_d = ctl.word_new;
			end
			CELL_REMOVE: begin
				if (idx >= ctl.pos_a)
					data_d = right;
			end
			CELL_SWAP: begin
				// equal positions: both read words are the same
				if (hit_a)
					data_d = ctl.word_b;
				else if (hit_b)
					data_d = ctl.word_a;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data  = data_q;
	assign sel_a = hit_a ? data_q : '0;
	assign sel_b = hit_b ? data_q : '0;

endmodule

[rtl/plsu_select.sv]
// ----------------------------------------------------------------------------
// plsu_select - registered read-out tree
// ORs the masked cell words in two registered levels: groups of GRP cells,
// then the group results. Only the selected cell drives a nonzero word.
// ----------------------------------------------------------------------------
module plsu_select (
	input  logic                          clk,
	input  logic [plsu_pkg::DATA_W-1:0]   words [plsu_pkg::ENTRIES],
	output logic [plsu_pkg::DATA_W-1:0]   word
);
	import plsu_pkg::*;

	logic [DATA_W-1:0] grp_d [NGRP];
	logic [DATA_W-1:0] grp_s1 [NGRP];
	logic [DATA_W-1:0] word_d;
	logic [DATA_W-1:0] word_s2;

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < ENTRIES)
					grp_d[g] = grp_d[g] | words[g * GRP + k];
			end
		end
	end

	always_comb begin
		word_d = '0;
		for (int g = 0; g < NGRP; g++)
			word_d = word_d | grp_s1[g];
	end

	always_ff @(posedge clk) begin
		grp_s1  <= grp_d;
		word_s2 <= word_d;
	end

	assign word = word_s2;

endmodule

[rtl/positional_list_store_unit.sv]
// ----------------------------------------------------------------------------
// positional_list_store_unit - ordered list of words addressed by position
// Insert, get, remove and swap on a row of storage cells that all shift
// together at write-back; reads go through a two-level registered OR tree.
// ----------------------------------------------------------------------------
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  request | in_valid, in_stall, kind, position,          | in
//          | second_position, value                       |
//  result  | out_valid, out_stall, result_value,          | out
//          | entry_count, status                          |
//
// A request passes through accept, two read-out tree levels and write-back.
// The write-back cycle updates all cells at once and loads the result register.
// A stalled result holds the write-back until the result register frees; a new
// request is taken as soon as the previous one is written back.
// Reset clears the fill count and handshake state, not the cell contents.
// ----------------------------------------------------------------------------
module positional_list_store_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [plsu_pkg::KIND_W-1:0]     kind,
	input  logic [plsu_pkg::POS_W-1:0]      position,
	input  logic [plsu_pkg::POS_W-1:0]      second_position,
	input  logic [plsu_pkg::VALUE_W-1:0]    value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [plsu_pkg::RESULT_W-1:0]   result_value,
	output logic [plsu_pkg::CNT_W-1:0]      entry_count,
	output logic [plsu_pkg::STATUS_W-1:0]   status
);
	import plsu_pkg::*;

	state_t             state_q;
	state_t             state_d;
	kind_t              kind_q;
	status_t            status_q;
	status_t            status_d;
	logic [IDX_W-1:0]   pos_a_q;
	logic [IDX_W-1:0]   pos_b_q;
	logic [DATA_W-1:0]  value_q;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   fill_d;
	logic               out_valid_q;
	logic [RESULT_W-1:0] result_value_q;
	logic [CNT_W-1:0]   entry_count_q;
	status_t            status_out_q;

	logic               in_acc;
	logic               wb_go;
	logic [CMP_W-1:0]   pa_cmp;
	logic [CMP_W-1:0]   pb_cmp;
	logic [CMP_W-1:0]   fill_cmp;
	cell_ctl_t          ctl;
	logic [DATA_W-1:0]  rd_a;
	logic [DATA_W-1:0]  rd_b;
	logic [DATA_W-1:0]  cell_data [ENTRIES];
	logic [DATA_W-1:0]  cell_sel_a [ENTRIES];
	logic [DATA_W-1:0]  cell_sel_b [ENTRIES];

	assign in_acc = in_valid && !in_stall;
	assign wb_go  = (state_q == S_WB) && (!out_valid_q || !out_stall);

	// request check against the current count
	assign pa_cmp   = CMP_W'(position);
	assign pb_cmp   = CMP_W'(second_position);
	assign fill_cmp = CMP_W'(fill_q);

	always_comb begin
		status_d = ST_OK;
		case (kind_t'(kind))
			KIND_INSERT: begin
				if (fill_q == CNT_W'(ENTRIES))
					status_d = ST_FULL;
				else if (pa_cmp > fill_cmp)
					status_d = ST_RANGE;
			end
			KIND_GET: begin
				if (pa_cmp >= fill_cmp)
					status_d = ST_RANGE;
			end
			KIND_REMOVE: begin
				if (fill_q == '0)
					status_d = ST_EMPTY;
				else if (pa_cmp >= fill_cmp)
					status_d = ST_RANGE;
			end
			KIND_SWAP: begin
				if (pa_cmp >= fill_cmp || pb_cmp >= fill_cmp)
					status_d = ST_RANGE;
			end
			default: status_d = ST_RANGE;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_RD1;
			S_RD1:  state_d = S_RD2;
			S_RD2:  state_d = S_WB;
			S_WB:   if (wb_go) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall     = (state_q != S_IDLE);
		ctl.op       = CELL_HOLD;
		ctl.pos_a    = pos_a_q;
		ctl.pos_b    = pos_b_q;
		ctl.word_new = value_q;
		ctl.word_a   = rd_a;
		ctl.word_b   = rd_b;
		if (wb_go && status_q == ST_OK) begin
			case (kind_q)
				KIND_INSERT: ctl.op = CELL_INSERT;
				KIND_REMOVE: ctl.op = CELL_REMOVE;
				KIND_SWAP:   ctl.op = CELL_SWAP;
				default:     ctl.op = CELL_HOLD;
			endcase
		end
	end

	always_comb begin
		fill_d = fill_q;
		if (wb_go && status_q == ST_OK) begin
			if (kind_q == KIND_INSERT)
				fill_d = fill_q + CNT_W'(1);
			else if (kind_q == KIND_REMOVE)
				fill_d = fill_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (wb_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q   <= kind_t'(kind);
			status_q <= status_d;
			pos_a_q  <= IDX_W'(position);
			pos_b_q  <= IDX_W'(second_position);
			value_q  <= DATA_W'(value);
		end
		if (wb_go) begin
			entry_count_q <= fill_d;
			status_out_q  <= status_q;
			if (status_q == ST_OK && (kind_q == KIND_GET || kind_q == KIND_REMOVE))
				result_value_q <= RESULT_W'(rd_a);
			else
				result_value_q <= '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign entry_count  = entry_count_q;
	assign status       = status_out_q;

	// row of cells; the ends see their own word as the missing neighbor
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (i == 0) begin : g_head
			assign left_w = cell_data[i];
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == ENTRIES - 1) begin : g_tail
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		plsu_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.idx   (IDX_W'(i)),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i]),
			.sel_a (cell_sel_a[i]),
			.sel_b (cell_sel_b[i])
		);
	end

	plsu_select u_sel_a (
		.clk   (clk),
		.words (cell_sel_a),
		.word  (rd_a)
	);

	plsu_select u_sel_b (
		.clk   (clk),
		.words (cell_sel_b),
		.word  (rd_b)
	);

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for positional_list_store_unit
// Drives insert, get, remove and swap requests through the valid/stall
// handshake with random bursts and result back-pressure. A directed table
// covers empty and range errors; then phased random traffic fills,
// mixes and drains the list. Each result is checked against the table's
// expected result or, where none is given, a local list predictor.
// ----------------------------------------------------------------------------
module tb_top;
	import plsu_pkg::*;

	localparam int RANDOM_ITEMS = 1900;
	localparam int IDLE_LIMIT   = 400;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		logic [RESULT_W-1:0] word;
		logic [CNT_W-1:0]    count;
		status_t             st;
	} list_result_t;

	typedef struct {
		kind_t               k;
		logic [POS_W-1:0]    p;
		logic [POS_W-1:0]    p2;
		logic [VALUE_W-1:0]  v;
		bit                  typed;
		logic [RESULT_W-1:0] word;
		logic [CNT_W-1:0]    count;
		status_t             st;
	} dir_row_t;

	typedef enum {PH_FILL, PH_MIXED, PH_DRAIN} phase_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [KIND_W-1:0]   kind;
	logic [POS_W-1:0]    position;
	logic [POS_W-1:0]    second_position;
	logic [VALUE_W-1:0]  value;
	logic                out_valid;
	logic                out_stall;
	logic [RESULT_W-1:0] result_value;
	logic [CNT_W-1:0]    entry_count;
	logic [STATUS_W-1:0] status;

	// predictor state
	logic [DATA_W-1:0] list_words [ENTRIES];
	int unsigned       list_len;

	list_result_t pending_results [$];
	int           mismatches;
	int           results_seen;
	int           burst_left;

	dir_row_t dir_rows [21] = '{
		'{KIND_GET,    8'd0,   8'd0,   32'h0,        1'b1, 32'h0,        9'd0, ST_RANGE},
		'{KIND_REMOVE, 8'd0,   8'd0,   32'h0,        1'b1, 32'h0,        9'd0, ST_EMPTY},
		'{KIND_SWAP,   8'd0,   8'd0,   32'h0,        1'b1, 32'h0,        9'd0, ST_RANGE},
		'{KIND_INSERT, 8'd1,   8'd0,   32'h12345678, 1'b1, 32'h0,        9'd0, ST_RANGE},
		'{KIND_INSERT, 8'd0,   8'd0,   32'hFFFFFFFF, 1'b1, 32'h0,        9'd1, ST_OK},
		'{KIND_INSERT, 8'd0,   8'd255, 32'h00000000, 1'b1, 32'h0,        9'd2, ST_OK},
		'{KIND_INSERT, 8'd2,   8'd0,   32'hA5A5A5A5, 1'b1, 32'h0,        9'd3, ST_OK},
		'{KIND_GET,    8'd1,   8'd0,   32'h0,        1'b1, 32'hFFFFFFFF, 9'd3, ST_OK},
		'{KIND_GET,    8'd3,   8'd0,   32'h0,        1'b1, 32'h0,        9'd3, ST_RANGE},
		'{KIND_SWAP,   8'd0,   8'd2,   32'hFFFFFFFF, 1'b1, 32'h0,        9'd3, ST_OK},
		'{KIND_SWAP,   8'd1,   8'd1,   32'h0,        1'b1, 32'h0,        9'd3, ST_OK},
		'{KIND_SWAP,   8'd0,   8'd255, 32'h0,        1'b1, 32'h0,        9'd3, ST_RANGE},
		'{KIND_SWAP,   8'd255, 8'd1,   32'h0,        1'b1, 32'h0,        9'd3, ST_RANGE},
		'{KIND_GET,    8'd0,   8'd0,   32'h0,        1'b0, 32'h0,        9'd0, ST_OK},
		'{KIND_GET,    8'd2,   8'd0,   32'h0,        1'b0, 32'h0,        9'd0, ST_OK},
		'{KIND_REMOVE, 8'd1,   8'd0,   32'h0,        1'b1, 32'hFFFFFFFF, 9'd2, ST_OK},
		'{KIND_REMOVE, 8'd2,   8'd0,   32'h0,        1'b1, 32'h0,        9'd2, ST_RANGE},
		'{KIND_INSERT, 8'd255, 8'd0,   32'h0,        1'b1, 32'h0,        9'd2, ST_RANGE},
		'{KIND_GET,    8'd255, 8'd0,   32'h0,        1'b1, 32'h0,        9'd2, ST_RANGE},
		'{KIND_REMOVE, 8'd0,   8'd0,   32'h0,        1'b0, 32'h0,        9'd0, ST_OK},
		'{KIND_INSERT, 8'd1,   8'd0,   32'h5A5A5A5A, 1'b0, 32'h0,        9'd0, ST_OK}
	};

	positional_list_store_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.position        (position),
		.second_position (second_position),
		.value           (value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_value    (result_value),
		.entry_count     (entry_count),
		.status          (status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// updates the predicted list and returns the result of one request
	function automatic list_result_t apply_list_op(kind_t k, logic [POS_W-1:0] p,
			logic [POS_W-1:0] p2, logic [VALUE_W-1:0] v);
		list_result_t      r;
		logic [DATA_W-1:0] t;
		int unsigned       i;
		r.word = '0;
		r.st   = ST_OK;
		case (k)
			KIND_INSERT: begin
				if (list_len >= ENTRIES) begin
					r.st = ST_FULL;
				end else if (p > list_len) begin
					r.st = ST_RANGE;
				end else begin
					for (i = list_len; i > p; i--)
						list_words[i] = list_words[i-1];
					list_words[p] = v[DATA_W-1:0];
					list_len++;
				end
			end
			KIND_GET: begin
				if (p >= list_len)
					r.st = ST_RANGE;
				else
					r.word = RESULT_W'(list_words[p]);
			end
			KIND_REMOVE: begin
				if (list_len == 0) begin
					r.st = ST_EMPTY;
				end else if (p >= list_len) begin
					r.st = ST_RANGE;
				end else begin
					r.word = RESULT_W'(list_words[p]);
					for (i = 32'(p); i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
				end
			end
			default: begin
				if (p >= list_len || p2 >= list_len) begin
					r.st = ST_RANGE;
				end else begin
					t              = list_words[p];
					list_words[p]  = list_words[p2];
					list_words[p2] = t;
				end
			end
		endcase
		r.count = CNT_W'(list_len);
		return r;
	endfunction

	// one request through the handshake; bursts of back-to-back requests
	// are separated by random gaps
	task automatic send_request(kind_t k, logic [POS_W-1:0] p, logic [POS_W-1:0] p2,
			logic [VALUE_W-1:0] v, bit typed, list_result_t typed_res);
		int           gap;
		list_result_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(30, 1);
		end
		burst_left--;
		in_valid        <= 1'b1;
		kind            <= k;
		position        <= p;
		second_position <= p2;
		value           <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		predicted = apply_list_op(k, p, p2, v);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	task automatic pick_request(phase_t ph, output kind_t k, output logic [POS_W-1:0] p,
			output logic [POS_W-1:0] p2, output logic [VALUE_W-1:0] v);
		int          roll;
		int unsigned top;
		roll = $urandom_range(99, 0);
		if ($urandom_range(9, 0) == 0) begin
			// noise: anything goes, mostly out of range
			k  = kind_t'($urandom_range(3, 0));
			p  = POS_W'($urandom_range(255, 0));
			p2 = POS_W'($urandom_range(255, 0));
		end else begin
			case (ph)
				PH_FILL:  k = roll < 75 ? KIND_INSERT : roll < 80 ? KIND_REMOVE :
						roll < 90 ? KIND_GET : KIND_SWAP;
				PH_DRAIN: k = roll < 75 ? KIND_REMOVE : roll < 80 ? KIND_INSERT :
						roll < 90 ? KIND_GET : KIND_SWAP;
				default:  k = roll < 30 ? KIND_INSERT : roll < 60 ? KIND_REMOVE :
						roll < 80 ? KIND_GET : KIND_SWAP;
			endcase
			if (k == KIND_INSERT) begin
				top = (list_len > 255) ? 255 : list_len;
				p   = POS_W'($urandom_range(top, 0));
			end else begin
				p = (list_len == 0) ? POS_W'($urandom_range(255, 0)) :
					POS_W'($urandom_range(list_len - 1, 0));
			end
			if ($urandom_range(7, 0) == 0)
				p2 = p;
			else
				p2 = (list_len == 0) ? POS_W'($urandom_range(255, 0)) :
					POS_W'($urandom_range(list_len - 1, 0));
		end
		case ($urandom_range(9, 0))
			0:       v = '0;
			1:       v = '1;
			default: v = $urandom();
		endcase
	endtask

	initial begin
		list_result_t      typed_res;
		kind_t             k;
		logic [POS_W-1:0]  p;
		logic [POS_W-1:0]  p2;
		logic [VALUE_W-1:0] v;
		phase_t            ph;
		int                sent;
		int                phase_items;
		int                tail;
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		kind            <= KIND_INSERT;
		position        <= '0;
		second_position <= '0;
		value           <= '0;
		list_len     = 0;
		mismatches   = 0;
		results_seen = 0;
		burst_left   = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			typed_res.word  = dir_rows[i].word;
			typed_res.count = dir_rows[i].count;
			typed_res.st    = dir_rows[i].st;
			send_request(dir_rows[i].k, dir_rows[i].p, dir_rows[i].p2, dir_rows[i].v,
				dir_rows[i].typed, typed_res);
		end

		// fill to full, mix, drain to empty, mix, and around again
		ph          = PH_FILL;
		sent        = 0;
		phase_items = 0;
		tail        = 0;
		while (sent < RANDOM_ITEMS) begin
			pick_request(ph, k, p, p2, v);
			send_request(k, p, p2, v, 1'b0, typed_res);
			sent++;
			phase_items++;
			if ((ph == PH_FILL && list_len == ENTRIES) || (ph == PH_DRAIN && list_len == 0))
				tail++;
			if (tail >= 4 || (ph == PH_MIXED && phase_items >= 150)) begin
				if (ph != PH_MIXED)
					ph = PH_MIXED;
				else
					ph = (list_len > ENTRIES / 2) ? PH_DRAIN : PH_FILL;
				phase_items = 0;
				tail        = 0;
			end
		end
		in_valid <= 1'b0;

		while (pending_results.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("positional_list_store_unit: match");
		else
			$display("positional_list_store_unit: mismatch");
		$finish;
	end

	// result back-pressure: free-flowing, sparse random, or long runs
	initial begin
		int mode;
		int run;
		int cyc;
		bit st;
		out_stall <= 1'b0;
		mode = 0;
		run  = 0;
		cyc  = 0;
		st   = 1'b0;
		forever begin
			@(posedge clk);
			if (cyc % 64 == 0)
				mode = $urandom_range(2, 0);
			cyc++;
			case (mode)
				0: st = 1'b0;
				1: st = ($urandom_range(9, 0) < 3);
				default: begin
					if (run == 0) begin
						st  = !st;
						run = st ? $urandom_range(10, 1) : $urandom_range(5, 1);
					end
					run--;
				end
			endcase
			out_stall <= st;
		end
	end

	always @(posedge clk) begin
		list_result_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display({"result %0d with no request pending: ",
						"value %h count %0d status %0d"},
						results_seen, result_value, entry_count, status);
			end else begin
				want = pending_results.pop_front();
				if (result_value !== want.word || entry_count !== want.count ||
						status !== want.st) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"result %0d: expected value %h count %0d status %0d, ",
							"got value %h count %0d status %0d"},
							results_seen, want.word, want.count, want.st,
							result_value, entry_count, status);
				end
			end
		end
	end

	// stops a hung run: too many cycles with no transfer on either side
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("positional_list_store_unit: mismatch");
		$finish;
	end

endmodule
